// ----- rtl/minv3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3 package
// Shared constants: dimension, element count, and the cofactor and column index tables.
// ----------------------------------------------------------------------------
package minv3_pkg;

  localparam int unsigned DIM      = 3;
  localparam int unsigned NUM_ELEM = DIM * DIM;

  // Adjugate entry k (row-major) is a[X]*a[Y] - a[Z]*a[V], elements row-major.
  localparam int unsigned COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // First-column elements used for the determinant expansion.
  localparam int unsigned COL_IDX [DIM] = '{0, 3, 6};

endpackage
`default_nettype wire

// ----- rtl/minv3_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3 channel interfaces
// Valid/ready channels for the input matrix and the result matrix.
// ----------------------------------------------------------------------------
interface minv3_in_if #(parameter int unsigned ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] a_r0_c0, a_r0_c1, a_r0_c2;
  logic signed [ELEM_WIDTH-1:0] a_r1_c0, a_r1_c1, a_r1_c2;
  logic signed [ELEM_WIDTH-1:0] a_r2_c0, a_r2_c1, a_r2_c2;

  modport source (output valid, a_r0_c0, a_r0_c1, a_r0_c2, a_r1_c0, a_r1_c1,
                  a_r1_c2, a_r2_c0, a_r2_c1, a_r2_c2, input ready);
  modport sink   (input valid, a_r0_c0, a_r0_c1, a_r0_c2, a_r1_c0, a_r1_c1,
                  a_r1_c2, a_r2_c0, a_r2_c1, a_r2_c2, output ready);
endinterface

interface minv3_out_if #(parameter int unsigned ELEM_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] inv_r0_c0, inv_r0_c1, inv_r0_c2;
  logic signed [ELEM_WIDTH-1:0] inv_r1_c0, inv_r1_c1, inv_r1_c2;
  logic signed [ELEM_WIDTH-1:0] inv_r2_c0, inv_r2_c1, inv_r2_c2;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0,
                  inv_r1_c1, inv_r1_c2, inv_r2_c0, inv_r2_c1, inv_r2_c2,
                  singular, saturated, input ready);
  modport sink   (input valid, inv_r0_c0, inv_r0_c1, inv_r0_c2, inv_r1_c0,
                  inv_r1_c1, inv_r1_c2, inv_r2_c0, inv_r2_c1, inv_r2_c2,
                  singular, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/minv3_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3 front end
// Pipelined cofactors and determinant, then sign/magnitude classification.
// ----------------------------------------------------------------------------
module minv3_front
  import minv3_pkg::*;
#(
  parameter int unsigned EW = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [NUM_ELEM-1:0][EW-1:0]         a_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic                                sing_o,
  output      logic [NUM_ELEM-1:0]                 adj_neg_o,
  output      logic                                det_neg_o,
  output      logic [NUM_ELEM-1:0][2*EW:0]         adj_abs_o,
  output      logic [3*EW+2:0]                     det_abs_o
);

  localparam int unsigned NSTG = 7;

  logic [NSTG-1:0] v_q;
  logic            en;

  logic [NUM_ELEM-1:0][EW-1:0]   a_q;
  logic [NUM_ELEM-1:0][2*EW-1:0] p0_q, p1_q;
  logic [DIM-1:0][EW-1:0]        col2_q, col3_q;
  logic [NUM_ELEM-1:0][2*EW:0]   adj3_q, adj4_q, adj5_q, adj6_q;
  logic [DIM-1:0][2*EW:0]        ph_q, pl_q;
  logic [DIM-1:0][3*EW:0]        pr_q;
  logic [3*EW+2:0]               det_q;

  // The whole pipe advances whenever its last stage is free or drained.
  assign en          = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q    <= a_i;
      col3_q <= col2_q;
      adj4_q <= adj3_q;
      adj5_q <= adj4_q;
      adj6_q <= adj5_q;
      det_q  <= {{2{pr_q[0][3*EW]}}, pr_q[0]} + {{2{pr_q[1][3*EW]}}, pr_q[1]}
              + {{2{pr_q[2][3*EW]}}, pr_q[2]};
      sing_o    <= (det_q == '0);
      det_neg_o <= det_q[3*EW+2];
      det_abs_o <= det_q[3*EW+2] ? (3*EW+3)'(-det_q) : det_q;
    end
  end

  for (genvar k = 0; k < NUM_ELEM; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en) begin
        p0_q[k] <= $signed(a_q[COF_IDX[k][0]]) * $signed(a_q[COF_IDX[k][1]]);
        p1_q[k] <= $signed(a_q[COF_IDX[k][2]]) * $signed(a_q[COF_IDX[k][3]]);
        adj3_q[k] <= {p0_q[k][2*EW-1], p0_q[k]} - {p1_q[k][2*EW-1], p1_q[k]};
        adj_neg_o[k] <= adj6_q[k][2*EW];
        adj_abs_o[k] <= adj6_q[k][2*EW] ? (2*EW+1)'(-adj6_q[k]) : adj6_q[k];
      end
    end
  end

  // Determinant terms: each first-row adjugate entry is split into a signed high part
  // and an unsigned low part so every multiply stays element sized.
  for (genvar j = 0; j < DIM; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en) begin
        col2_q[j] <= a_q[COL_IDX[j]];
        ph_q[j]   <= $signed(col3_q[j]) * $signed(adj3_q[j][2*EW:EW]);
        pl_q[j]   <= $signed(col3_q[j]) * $signed({1'b0, adj3_q[j][EW-1:0]});
        pr_q[j]   <= {ph_q[j], {EW{1'b0}}} + {{EW{pl_q[j][2*EW]}}, pl_q[j]};
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/minv3_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3 decoupling queue
// Small first-word-fall-through FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module minv3_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  output      logic             wr_ready_o,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output      logic             rd_valid_o,
  input  wire logic             rd_ready_i,
  output      logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]   LAST = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CNTW-1:0]  cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + AW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/minv3_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3 back end
// Nine-lane pipelined restoring divider with rounding and saturation.
// ----------------------------------------------------------------------------
module minv3_back
  import minv3_pkg::*;
#(
  parameter int unsigned EW = 32,
  parameter int unsigned FB = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic                        sing_i,
  input  wire logic [NUM_ELEM-1:0]         adj_neg_i,
  input  wire logic                        det_neg_i,
  input  wire logic [NUM_ELEM-1:0][2*EW:0] adj_abs_i,
  input  wire logic [3*EW+2:0]             det_abs_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [NUM_ELEM-1:0][EW-1:0] inv_o,
  output      logic                        singular_o,
  output      logic                        saturated_o
);

  localparam int unsigned CW   = 2 * EW + 1;
  localparam int unsigned DW   = 3 * EW + 3;
  localparam int unsigned DDW  = DW + 1;
  localparam int unsigned QB   = EW + 1;
  localparam int unsigned NW0  = CW + 2 * FB + 1;
  localparam int unsigned NW   = ((NW0 > DW) ? NW0 : DW) + 1;
  localparam int unsigned RW0  = DDW + QB;
  localparam int unsigned RW   = (NW > RW0) ? NW : RW0;
  localparam int unsigned LAST = QB + 1;
  localparam int unsigned NS   = QB + 3;

  localparam logic [QB-1:0] LIM_Q    = QB'(1) << (EW - 1);
  localparam logic [EW-1:0] MAX_POS  = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] MIN_NEG  = {1'b1, {(EW-1){1'b0}}};
  localparam bit            ONE_FITS = (FB < EW - 1);
  localparam logic [EW-1:0] ONE_VAL  = ONE_FITS ? (EW'(1) << FB) : MAX_POS;

  logic [NS-1:0]                        v_q;
  logic                                 en;
  logic [LAST:0][NUM_ELEM-1:0][RW-1:0]  rem_q;
  logic [LAST:0][NUM_ELEM-1:0][QB-1:0]  quo_q;
  logic [LAST:0][NUM_ELEM-1:0]          neg_q;
  logic [LAST:0][NUM_ELEM-1:0]          ovf_q;
  logic [LAST:0][DDW-1:0]               dn_q;
  logic [LAST:0]                        sing_q;
  logic [NUM_ELEM-1:0][EW-1:0]          res_d;
  logic [NUM_ELEM-1:0]                  sat_d;

  assign en          = !v_q[NS-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Load: numerator |adj| * 2^(2F+1) + |det|, denominator 2|det|, so the
  // truncating quotient is the quotient rounded half away from zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dn_q[0]   <= {det_abs_i, 1'b0};
      sing_q[0] <= sing_i;
      dn_q[1]   <= dn_q[0];
      sing_q[1] <= sing_q[0];
      inv_o       <= res_d;
      singular_o  <= sing_q[LAST];
      saturated_o <= |sat_d;
    end
  end

  for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
    localparam bit DIAG = (l % 4 == 0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[0][l] <= (RW'(adj_abs_i[l]) << (2 * FB + 1)) + RW'(det_abs_i);
        quo_q[0][l] <= '0;
        neg_q[0][l] <= adj_neg_i[l] ^ det_neg_i;
        ovf_q[0][l] <= 1'b0;
        // Quotient wider than QB bits saturates regardless of its value.
        ovf_q[1][l] <= ovf_q[0][l] || (rem_q[0][l] >= (RW'(dn_q[0]) << QB));
        rem_q[1][l] <= rem_q[0][l];
        quo_q[1][l] <= quo_q[0][l];
        neg_q[1][l] <= neg_q[0][l];
      end
    end

    always_comb begin
      sat_d[l] = 1'b0;
      res_d[l] = '0;
      if (sing_q[LAST]) begin
        if (DIAG) begin
          res_d[l] = ONE_VAL;
          sat_d[l] = !ONE_FITS;
        end
      end else if (!neg_q[LAST][l]) begin
        if (ovf_q[LAST][l] || (quo_q[LAST][l] >= LIM_Q)) begin
          res_d[l] = MAX_POS;
          sat_d[l] = 1'b1;
        end else begin
          res_d[l] = quo_q[LAST][l][EW-1:0];
        end
      end else begin
        if (ovf_q[LAST][l] || (quo_q[LAST][l] > LIM_Q)) begin
          res_d[l] = MIN_NEG;
          sat_d[l] = 1'b1;
        end else begin
          res_d[l] = EW'(-quo_q[LAST][l][EW-1:0]);
        end
      end
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar i = 2; i <= LAST; i++) begin : g_div
    localparam int unsigned K = LAST - i;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dn_q[i]   <= dn_q[i-1];
        sing_q[i] <= sing_q[i-1];
      end
    end

    for (genvar l = 0; l < NUM_ELEM; l++) begin : g_dl
      logic [RW:0] cand;

      assign cand = {1'b0, rem_q[i-1][l]} - {1'b0, (RW'(dn_q[i-1]) << K)};

      always_ff @(posedge clk_i) begin
        if (en) begin
          rem_q[i][l] <= cand[RW] ? rem_q[i-1][l] : cand[RW-1:0];
          quo_q[i][l] <= quo_q[i-1][l] | (QB'(!cand[RW]) << K);
          neg_q[i][l] <= neg_q[i-1][l];
          ovf_q[i][l] <= ovf_q[i-1][l];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/matrix_inverse_3x3.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Matrix inverse 3x3
// Streams signed fixed-point 3x3 matrices in and their inverses out.
// ----------------------------------------------------------------------------
// Usage: one beat on in_i carries a whole 3x3 matrix; one beat on out_o
// returns its inverse plus the singular and saturated flags, in order.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The inverse is adjugate / determinant, rounded to nearest with ties away
// from zero and clipped to the element range. A zero determinant returns
// the identity matrix with singular set; a one that does not fit is clipped.
// Throughput is one matrix per cycle while out_o does not stall. A matrix
// passes seven front stages (cofactor products, cofactors, split
// determinant products and sum, sign/magnitude), the queue, and
// ELEM_WIDTH + 4 back stages, most of them the restoring divider that resolves
// one quotient bit per stage in each of nine lanes.
// Reset clears all valid state; no matrix is in flight afterwards.
// When the receiver stalls, the back pipe holds, the queue of QUEUE_DEPTH
// beats fills, then the front pipe holds and in_i drops ready.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
  import minv3_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH  = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  minv3_in_if.sink   in_i,
  minv3_out_if.source out_o
);

  localparam int unsigned CW = 2 * ELEM_WIDTH + 1;
  localparam int unsigned DW = 3 * ELEM_WIDTH + 3;
  localparam int unsigned QW = 1 + NUM_ELEM + 1 + NUM_ELEM * CW + DW;

  logic [NUM_ELEM-1:0][ELEM_WIDTH-1:0] a;
  logic [NUM_ELEM-1:0][ELEM_WIDTH-1:0] inv;

  // Front to queue.
  logic                        f_valid, f_ready, f_sing, f_det_neg;
  logic [NUM_ELEM-1:0]         f_adj_neg;
  logic [NUM_ELEM-1:0][CW-1:0] f_adj_abs;
  logic [DW-1:0]               f_det_abs;
  logic [QW-1:0]               f_data;

  // Queue to back.
  logic                        b_valid, b_ready, b_sing, b_det_neg;
  logic [NUM_ELEM-1:0]         b_adj_neg;
  logic [NUM_ELEM-1:0][CW-1:0] b_adj_abs;
  logic [DW-1:0]               b_det_abs;
  logic [QW-1:0]               b_data;

  assign a = {in_i.a_r2_c2, in_i.a_r2_c1, in_i.a_r2_c0,
              in_i.a_r1_c2, in_i.a_r1_c1, in_i.a_r1_c0,
              in_i.a_r0_c2, in_i.a_r0_c1, in_i.a_r0_c0};

  minv3_front #(
    .EW (ELEM_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .a_i         (a),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .sing_o      (f_sing),
    .adj_neg_o   (f_adj_neg),
    .det_neg_o   (f_det_neg),
    .adj_abs_o   (f_adj_abs),
    .det_abs_o   (f_det_abs)
  );

  assign f_data = {f_sing, f_adj_neg, f_det_neg, f_adj_abs, f_det_abs};

  minv3_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_data),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_data)
  );

  assign {b_sing, b_adj_neg, b_det_neg, b_adj_abs, b_det_abs} = b_data;

  minv3_back #(
    .EW (ELEM_WIDTH),
    .FB (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .sing_i      (b_sing),
    .adj_neg_i   (b_adj_neg),
    .det_neg_i   (b_det_neg),
    .adj_abs_i   (b_adj_abs),
    .det_abs_i   (b_det_abs),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .inv_o       (inv),
    .singular_o  (out_o.singular),
    .saturated_o (out_o.saturated)
  );

  assign out_o.inv_r0_c0 = inv[0];
  assign out_o.inv_r0_c1 = inv[1];
  assign out_o.inv_r0_c2 = inv[2];
  assign out_o.inv_r1_c0 = inv[3];
  assign out_o.inv_r1_c1 = inv[4];
  assign out_o.inv_r1_c2 = inv[5];
  assign out_o.inv_r2_c0 = inv[6];
  assign out_o.inv_r2_c1 = inv[7];
  assign out_o.inv_r2_c2 = inv[8];

endmodule
`default_nettype wire
